// ===== rtl/core/csc_pkg.sv =====
// shared types and constants for the character sprite compositor
// no dependencies; used by csc_milli_div and character_sprite_compositor
package csc_pkg;

  localparam logic [2:0] FN_APPEND   = 3'd0;
  localparam logic [2:0] FN_UPDATE   = 3'd1;
  localparam logic [2:0] FN_REMOVE   = 3'd2;
  localparam logic [2:0] FN_IMG_WR   = 3'd3;
  localparam logic [2:0] FN_BG_WR    = 3'd4;
  localparam logic [2:0] FN_READ     = 3'd5;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_FULL    = 2'd1;
  localparam logic [1:0] STS_NO_SLOT = 2'd2;
  localparam logic [1:0] STS_OFF_SCR = 2'd3;

  localparam logic [7:0] BLANK_CHAR  = 8'h20;
  localparam logic [7:0] OFF_CHAR    = 8'hFF;

  // x / 1000 == (x * MILLI_RECIP) >> MILLI_SHIFT for 0 <= x < 2**24
  localparam int unsigned MILLI_SHIFT = 33;
  localparam logic [23:0] MILLI_RECIP = 24'd8589935;

  // image address before wrap: base + width * row + column
  localparam int unsigned IA_W = 13;

  typedef struct packed {
    logic [2:0]         func;
    logic [5:0]         slot;
    logic signed [23:0] pos_x_milli;
    logic signed [23:0] pos_y_milli;
    logic [6:0]         img_width;
    logic [4:0]         img_height;
    logic [11:0]        img_base;
    logic [11:0]        mem_address;
    logic [6:0]         cell_x;
    logic [4:0]         cell_y;
    logic [7:0]         char_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       from_sprite;
    logic [1:0] op_status;
    logic [6:0] sprite_count;
  } out_item_t;

  typedef struct packed {
    logic signed [23:0] pos_x_milli;
    logic signed [23:0] pos_y_milli;
    logic [6:0]         img_width;
    logic [4:0]         img_height;
    logic [11:0]        img_base;
  } sprite_entry_t;

endpackage

// ===== rtl/core/csc_milli_div.sv =====
// signed division by 1000 with truncation toward zero, registered product
// reciprocal multiply on the magnitude; depends on csc_pkg
module csc_milli_div import csc_pkg::*; (
  input  logic               clk,
  input  logic signed [23:0] milli,
  output logic signed [15:0] cells
);

  logic [24:0] mag;
  logic [47:0] prod_r;
  logic        neg_r;
  logic [14:0] q;

  // magnitude of -2**23 needs the 24th bit
  assign mag = milli[23] ? (25'd0 - {milli[23], milli}) : {1'b0, milli};

  always_ff @(posedge clk) begin
    prod_r <= mag[23:0] * MILLI_RECIP;
    neg_r  <= milli[23];
  end

  assign q     = prod_r[47:MILLI_SHIFT];
  assign cells = neg_r ? (16'sd0 - $signed({1'b0, q})) : $signed({1'b0, q});

endmodule

// ===== rtl/core/character_sprite_compositor.sv =====
// character sprite compositor: background store, image memory, sprite table
// top level; depends on csc_pkg and csc_milli_div
//
// One item at a time, one result per item. After reset a clearing pass writes
// a space to all SCREEN_WIDTH*SCREEN_HEIGHT background cells, no transfer is
// taken meanwhile. Append and update go from dispatch to the output register;
// background write adds a write step, image write the address wrap. Remove
// moves each later entry down, one table read and one write each. A cell
// read visits sprites from the newest down, with a table read, a wait and a
// divide step each, plus the address wrap and an image byte fetch when the
// sprite covers the cell, then a background read as fallback; the single
// table read port and the image memory read set these steps. Image addresses
// wrap by repeated subtraction of IMAGE_MEM_DEPTH, one step a cycle.
module character_sprite_compositor import csc_pkg::*; #(
  parameter int SCREEN_WIDTH    = 96,
  parameter int SCREEN_HEIGHT   = 24,
  parameter int MAX_SPRITES     = 64,
  parameter int IMAGE_MEM_DEPTH = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int BG_DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int BG_AW    = $clog2(BG_DEPTH);
  localparam int TAB_AW   = $clog2(MAX_SPRITES);
  localparam int CNT_W    = $clog2(MAX_SPRITES + 1);
  localparam int CMP_W    = (CNT_W > 7) ? CNT_W + 1 : 8;
  localparam int IMG_AW   = $clog2(IMAGE_MEM_DEPTH);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_CLEAR    = 13'b0000000000010,
    S_DISP     = 13'b0000000000100,
    S_BG_WR    = 13'b0000000001000,
    S_REM_RD   = 13'b0000000010000,
    S_REM_WR   = 13'b0000000100000,
    S_WALK_RD  = 13'b0000001000000,
    S_WALK_TAB = 13'b0000010000000,
    S_WALK_DIV = 13'b0000100000000,
    S_WRAP     = 13'b0001000000000,
    S_IMG_CHK  = 13'b0010000000000,
    S_BG_RD    = 13'b0100000000000,
    S_DONE     = 13'b1000000000000
  } state_t;

  state_t              state_r, state_nxt;
  in_item_t            req_r, req_nxt;
  logic [BG_AW-1:0]    cell_addr_r, cell_addr_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [TAB_AW-1:0]   idx_r, idx_nxt;
  logic [IA_W-1:0]     img_addr_r, img_addr_nxt;
  logic [BG_AW-1:0]    clr_r, clr_nxt;
  logic [7:0]          res_char_r, res_char_nxt;
  logic                res_spr_r, res_spr_nxt;
  logic [1:0]          res_sts_r, res_sts_nxt;
  logic                out_valid_r;
  out_item_t           out_data_r;

  sprite_entry_t       tab_mem [MAX_SPRITES];
  sprite_entry_t       tab_rdata;
  logic                tab_we;
  logic [TAB_AW-1:0]   tab_waddr;
  sprite_entry_t       tab_wdata;

  logic [7:0]          img_mem [IMAGE_MEM_DEPTH];
  logic [7:0]          img_rdata;
  logic                img_we;

  logic [7:0]          bg_mem [BG_DEPTH];
  logic [7:0]          bg_rdata;
  logic                bg_we;
  logic [BG_AW-1:0]    bg_waddr;
  logic [7:0]          bg_wdata;

  logic signed [15:0]  qx, qy;
  logic signed [15:0]  cx, cy;
  logic                covered;
  logic [11:0]         row_off;
  logic                on_screen;
  logic                accept;
  logic                out_free;
  logic [CMP_W-1:0]    slot_w;
  logic [CMP_W-1:0]    count_w;
  sprite_entry_t       req_ent;

  csc_milli_div u_div_x (.clk(clk), .milli(tab_rdata.pos_x_milli), .cells(qx));
  csc_milli_div u_div_y (.clk(clk), .milli(tab_rdata.pos_y_milli), .cells(qy));

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign on_screen = ({2'b00, req_r.cell_x} < 9'(SCREEN_WIDTH)) &&
                     ({3'b000, req_r.cell_y} < 8'(SCREEN_HEIGHT));
  assign slot_w    = CMP_W'(req_r.slot);
  assign count_w   = CMP_W'(count_r);

  assign req_ent.pos_x_milli = req_r.pos_x_milli;
  assign req_ent.pos_y_milli = req_r.pos_y_milli;
  assign req_ent.img_width   = req_r.img_width;
  assign req_ent.img_height  = req_r.img_height;
  assign req_ent.img_base    = req_r.img_base;

  // sprite-relative cell and coverage test
  assign cx      = $signed({9'd0, req_r.cell_x}) - qx;
  assign cy      = $signed({11'd0, req_r.cell_y}) - qy;
  assign covered = !cx[15] && !cy[15] &&
                   (cx < $signed({9'd0, tab_rdata.img_width})) &&
                   (cy < $signed({11'd0, tab_rdata.img_height}));
  assign row_off = tab_rdata.img_width * cy[4:0];

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    cell_addr_nxt = cell_addr_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    img_addr_nxt  = img_addr_r;
    clr_nxt       = clr_r;
    res_char_nxt  = res_char_r;
    res_spr_nxt   = res_spr_r;
    res_sts_nxt   = res_sts_r;
    tab_we        = 1'b0;
    tab_waddr     = idx_r;
    tab_wdata     = tab_rdata;
    img_we        = 1'b0;
    bg_we         = 1'b0;
    bg_waddr      = cell_addr_r;
    bg_wdata      = req_r.char_value;

    case (state_r)
      S_CLEAR: begin
        bg_we    = 1'b1;
        bg_waddr = clr_r;
        bg_wdata = BLANK_CHAR;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == BG_AW'(BG_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          req_nxt       = in_data;
          cell_addr_nxt = BG_AW'(in_data.cell_y * SCREEN_WIDTH) + BG_AW'(in_data.cell_x);
          state_nxt     = S_DISP;
        end
      end
      S_DISP: begin
        res_char_nxt = 8'd0;
        res_spr_nxt  = 1'b0;
        res_sts_nxt  = STS_OK;
        state_nxt    = S_DONE;
        case (req_r.func)
          FN_APPEND: begin
            if (count_r == CNT_W'(MAX_SPRITES)) begin
              res_sts_nxt = STS_FULL;
            end else begin
              tab_we    = 1'b1;
              tab_waddr = TAB_AW'(count_r);
              tab_wdata = req_ent;
              count_nxt = count_r + 1'b1;
            end
          end
          FN_UPDATE: begin
            if (slot_w >= count_w) begin
              res_sts_nxt = STS_NO_SLOT;
            end else begin
              tab_we    = 1'b1;
              tab_waddr = TAB_AW'(req_r.slot);
              tab_wdata = req_ent;
            end
          end
          FN_REMOVE: begin
            if (slot_w >= count_w) begin
              res_sts_nxt = STS_NO_SLOT;
            end else if (slot_w + 1'b1 < count_w) begin
              idx_nxt   = TAB_AW'(slot_w + 1'b1);
              state_nxt = S_REM_RD;
            end else begin
              count_nxt = count_r - 1'b1;
            end
          end
          FN_IMG_WR: begin
            img_addr_nxt = IA_W'(req_r.mem_address);
            state_nxt    = S_WRAP;
          end
          FN_BG_WR: begin
            if (!on_screen) begin
              res_sts_nxt  = STS_OFF_SCR;
              res_char_nxt = OFF_CHAR;
            end else begin
              state_nxt = S_BG_WR;
            end
          end
          FN_READ: begin
            if (!on_screen) begin
              res_sts_nxt = STS_OFF_SCR;
            end else if (count_r == '0) begin
              state_nxt = S_BG_RD;
            end else begin
              idx_nxt   = TAB_AW'(count_r - 1'b1);
              state_nxt = S_WALK_RD;
            end
          end
          default: begin
          end
        endcase
      end
      S_BG_WR: begin
        res_char_nxt = bg_rdata;
        bg_we        = 1'b1;
        state_nxt    = S_DONE;
      end
      S_REM_RD: begin
        state_nxt = S_REM_WR;
      end
      S_REM_WR: begin
        // move entry idx down by one place
        tab_we    = 1'b1;
        tab_waddr = idx_r - 1'b1;
        tab_wdata = tab_rdata;
        if (CNT_W'(idx_r) + 1'b1 < count_r) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_REM_RD;
        end else begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_WALK_RD: begin
        state_nxt = S_WALK_TAB;
      end
      S_WALK_TAB: begin
        state_nxt = S_WALK_DIV;
      end
      S_WALK_DIV: begin
        img_addr_nxt = IA_W'(tab_rdata.img_base) + IA_W'(row_off) + IA_W'(cx[6:0]);
        if (covered) begin
          state_nxt = S_WRAP;
        end else if (idx_r == '0) begin
          state_nxt = S_BG_RD;
        end else begin
          idx_nxt   = idx_r - 1'b1;
          state_nxt = S_WALK_RD;
        end
      end
      S_WRAP: begin
        if (17'(img_addr_r) >= 17'(IMAGE_MEM_DEPTH)) begin
          img_addr_nxt = img_addr_r - IA_W'(IMAGE_MEM_DEPTH);
        end else if (req_r.func == FN_IMG_WR) begin
          img_we    = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_IMG_CHK;
        end
      end
      S_IMG_CHK: begin
        if (img_rdata != 8'd0) begin
          res_char_nxt = img_rdata;
          res_spr_nxt  = 1'b1;
          state_nxt    = S_DONE;
        end else if (idx_r == '0) begin
          state_nxt = S_BG_RD;
        end else begin
          idx_nxt   = idx_r - 1'b1;
          state_nxt = S_WALK_RD;
        end
      end
      S_BG_RD: begin
        res_char_nxt = bg_rdata;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      count_r     <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      clr_r   <= clr_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    cell_addr_r <= cell_addr_nxt;
    idx_r       <= idx_nxt;
    img_addr_r  <= img_addr_nxt;
    res_char_r  <= res_char_nxt;
    res_spr_r   <= res_spr_nxt;
    res_sts_r   <= res_sts_nxt;
    if (state_r == S_DONE && out_free) begin
      out_data_r.char_out     <= res_char_r;
      out_data_r.from_sprite  <= res_spr_r;
      out_data_r.op_status    <= res_sts_r;
      out_data_r.sprite_count <= 7'(count_r);
    end
  end

  // sprite table, read address follows the walk or move index
  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
    tab_rdata <= tab_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (img_we) begin
      img_mem[IMG_AW'(img_addr_r)] <= req_r.char_value;
    end
    img_rdata <= img_mem[IMG_AW'(img_addr_r)];
  end

  always_ff @(posedge clk) begin
    if (bg_we) begin
      bg_mem[bg_waddr] <= bg_wdata;
    end
    bg_rdata <= bg_mem[cell_addr_r];
  end

endmodule
